/* rtl/fifo_queue_with_count_queries_top_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros used by the queue sequencer (fqcq_ctrl).
// Each macro samples on i_clk and is disabled while i_rst_n is low.
// ---------------------------------------------------------------------------
`ifndef FIFO_QUEUE_WITH_COUNT_QUERIES_TOP_ASSERT_SVH
`define FIFO_QUEUE_WITH_COUNT_QUERIES_TOP_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define FQCQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define FQCQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/fqcq_pkg.sv */
// ---------------------------------------------------------------------------
// fqcq_pkg
// Types, constants and pointer helpers for the queue with count queries.
// ---------------------------------------------------------------------------
package fqcq_pkg;

    localparam int DEPTH   = 16;
    localparam int WORD_W  = 32;
    localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int FIELD_W = 5;

    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FILL_MAX = CNT_W'(DEPTH);

    typedef enum logic [1:0] {
        REQ_PUSH    = 2'd0,
        REQ_POP     = 2'd1,
        REQ_COUNT   = 2'd2,
        REQ_REVERSE = 2'd3
    } t_req_kind;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        logic [1:0]               req_type;
        logic signed [WORD_W-1:0] value;
    } t_req;

    typedef struct packed {
        logic signed [WORD_W-1:0] data_out;
        logic [FIELD_W-1:0]       match_count;
        logic [FIELD_W-1:0]       even_count;
        logic [FIELD_W-1:0]       occupancy;
        logic [1:0]               status;
    } t_rsp;

    // One access request to the word store.
    typedef struct packed {
        logic              we;
        logic [PTR_W-1:0]  waddr;
        logic [WORD_W-1:0] wdata;
        logic              re;
        logic [PTR_W-1:0]  raddr;
    } t_mem_req;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_LAST) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
        return (p == '0) ? PTR_LAST : p - 1'b1;
    endfunction

endpackage

/* rtl/fqcq_store.sv */
// ---------------------------------------------------------------------------
// fqcq_store
// Ring store of queue words: one write port, one read port, registered read.
// ---------------------------------------------------------------------------
module fqcq_store (
    input  logic                          i_clk,
    input  fqcq_pkg::t_mem_req            i_mem,
    output logic [fqcq_pkg::WORD_W-1:0]   o_rdata
);
    import fqcq_pkg::*;

    logic [WORD_W-1:0] r_mem [DEPTH];
    logic [WORD_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_mem.we) begin
            r_mem[i_mem.waddr] <= i_mem.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_mem.re) begin
            r_rdata <= r_mem[i_mem.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/fqcq_ctrl.sv */
// ---------------------------------------------------------------------------
// fqcq_ctrl
// Request sequencer: keeps the ring pointers and tallies, drives the store
// and walks the occupied span for count queries.
// ---------------------------------------------------------------------------
module fqcq_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_req_valid,
    input  fqcq_pkg::t_req                i_req,
    output logic                          o_idle,
    output fqcq_pkg::t_mem_req            o_mem,
    input  logic [fqcq_pkg::WORD_W-1:0]   i_rdata,
    output logic                          o_res_valid,
    output fqcq_pkg::t_rsp                o_res,
    input  logic                          i_res_take
);
    import fqcq_pkg::*;

    `include "fifo_queue_with_count_queries_top_assert.svh"

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_POP  = 4'b0010,
        S_CNT  = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state                   r_state, n_state;
    logic [PTR_W-1:0]         r_front, n_front;
    logic [PTR_W-1:0]         r_back, n_back;
    logic [CNT_W-1:0]         r_fill, n_fill;
    logic [CNT_W-1:0]         r_even, n_even;
    logic                     r_rev, n_rev;
    logic signed [WORD_W-1:0] r_thr, n_thr;
    logic [PTR_W-1:0]         r_walk, n_walk;
    logic [CNT_W-1:0]         r_left, n_left;
    logic [CNT_W-1:0]         r_match, n_match;
    t_rsp                     r_res, n_res;
    logic                     w_hit;
    logic [CNT_W-1:0]         w_match;
    logic                     w_acc;
    logic                     w_push_go;
    logic                     w_rev_go;
    logic                     w_done_take;

    assign w_acc   = (r_state == S_IDLE) && i_req_valid;
    assign w_hit   = $signed(i_rdata) > r_thr;
    assign w_match = r_match + CNT_W'(w_hit);

    always_comb begin
        n_state = r_state;
        n_front = r_front;
        n_back  = r_back;
        n_fill  = r_fill;
        n_even  = r_even;
        n_rev   = r_rev;
        n_thr   = r_thr;
        n_walk  = r_walk;
        n_left  = r_left;
        n_match = r_match;
        n_res   = r_res;
        o_mem   = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_res = '0;
                    unique case (i_req.req_type)
                        REQ_PUSH: begin
                            if (r_fill == FILL_MAX) begin
                                n_res.status = ST_FULL;
                            end else begin
                                o_mem.we    = 1'b1;
                                o_mem.wdata = i_req.value;
                                if (r_rev) begin
                                    n_front     = ptr_dec(r_front);
                                    o_mem.waddr = ptr_dec(r_front);
                                end else begin
                                    o_mem.waddr = r_back;
                                    n_back      = ptr_inc(r_back);
                                end
                                n_fill = r_fill + 1'b1;
                                if (!i_req.value[0]) begin
                                    n_even = r_even + 1'b1;
                                end
                            end
                            n_state = S_DONE;
                        end
                        REQ_POP: begin
                            if (r_fill == '0) begin
                                n_res.status = ST_EMPTY;
                                n_state      = S_DONE;
                            end else begin
                                o_mem.re = 1'b1;
                                if (r_rev) begin
                                    n_back      = ptr_dec(r_back);
                                    o_mem.raddr = ptr_dec(r_back);
                                end else begin
                                    o_mem.raddr = r_front;
                                    n_front     = ptr_inc(r_front);
                                end
                                n_fill  = r_fill - 1'b1;
                                n_state = S_POP;
                            end
                        end
                        REQ_COUNT: begin
                            n_thr = i_req.value;
                            if (r_fill == '0) begin
                                n_state = S_DONE;
                            end else begin
                                o_mem.re    = 1'b1;
                                o_mem.raddr = r_front;
                                n_walk      = ptr_inc(r_front);
                                n_left      = r_fill;
                                n_match     = '0;
                                n_state     = S_CNT;
                            end
                        end
                        REQ_REVERSE: begin
                            n_rev   = ~r_rev;
                            n_state = S_DONE;
                        end
                    endcase
                    n_res.even_count = FIELD_W'(n_even);
                    n_res.occupancy  = FIELD_W'(n_fill);
                end
            end
            S_POP: begin
                n_res.data_out = $signed(i_rdata);
                if (!i_rdata[0] && (r_even != '0)) begin
                    n_even = r_even - 1'b1;
                end
                n_res.even_count = FIELD_W'(n_even);
                n_state          = S_DONE;
            end
            S_CNT: begin
                n_match = w_match;
                n_left  = r_left - 1'b1;
                if (r_left == CNT_W'(1)) begin
                    n_res.match_count = FIELD_W'(w_match);
                    n_state           = S_DONE;
                end else begin
                    o_mem.re    = 1'b1;
                    o_mem.raddr = r_walk;
                    n_walk      = ptr_inc(r_walk);
                end
            end
            S_DONE: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_front <= '0;
            r_back  <= '0;
            r_fill  <= '0;
            r_even  <= '0;
            r_rev   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_front <= n_front;
            r_back  <= n_back;
            r_fill  <= n_fill;
            r_even  <= n_even;
            r_rev   <= n_rev;
        end
    end

    always_ff @(posedge i_clk) begin
        r_thr   <= n_thr;
        r_walk  <= n_walk;
        r_left  <= n_left;
        r_match <= n_match;
        r_res   <= n_res;
    end

    assign o_idle      = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_res       = r_res;

    assign w_push_go   = w_acc && (i_req.req_type == REQ_PUSH) && (r_fill != FILL_MAX);
    assign w_rev_go    = w_acc && (i_req.req_type == REQ_REVERSE);
    assign w_done_take = (r_state == S_DONE) && i_res_take;

    // A pop lowers the fill level before the parity of the popped
    // word is known, so the even tally may briefly lead it while in S_POP.
    `FQCQ_ASSERT_NOW(a_even_le_fill, r_state != S_POP, r_even <= r_fill, "even tally above fill")
    `FQCQ_ASSERT_NOW(a_walk_left, r_state == S_CNT, r_left != '0, "count walk with nothing left")
    `FQCQ_ASSERT_NEXT(a_push_fill, w_push_go, r_fill == $past(r_fill) + 1'b1, "push did not grow")
    `FQCQ_ASSERT_NEXT(a_rev_toggle, w_rev_go, r_rev != $past(r_rev), "reverse did not flip")
    `FQCQ_ASSERT_NEXT(a_done_leave, w_done_take, r_state == S_IDLE, "sequencer not idle")

endmodule

/* rtl/fifo_queue_with_count_queries_top.sv */
// ---------------------------------------------------------------------------
// fifo_queue_with_count_queries_top
// Bounded queue of signed words with push, pop, count-greater and reverse.
// ---------------------------------------------------------------------------
// Usage: a request beat (req_type, value) enters on i_in_valid and is taken
// at a clock edge where o_in_stall is low. Every request yields exactly one
// result beat on o_out_valid, held stable until an edge where i_out_stall is
// low. Results come out in request order.
// Sequence: push, reverse and any refused request pass through S_IDLE and
// S_DONE of the sequencer; pop also passes through S_POP, because the popped
// word comes from the store's registered read. A count query on a non-empty
// queue passes through S_CNT: the single read port of the word store is
// walked over the occupied span one word a cycle.
// The result moves into the output register as the sequencer leaves S_DONE.
// A finished result sits in the output register, so the next request is taken
// while the receiver still holds off the previous result; only when a second
// result is ready and the output register is still occupied does the sequencer
// wait, and then o_in_stall stays high.
// Reset (synchronous, active low) empties the queue, clears the tallies and
// restores normal order; the store contents are not cleared.
// ---------------------------------------------------------------------------
module fifo_queue_with_count_queries_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  fqcq_pkg::t_req    i_in_req,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output fqcq_pkg::t_rsp    o_out_rsp
);
    import fqcq_pkg::*;

    t_mem_req          w_mem;
    logic [WORD_W-1:0] w_rdata;
    logic              w_idle;
    logic              w_res_valid;
    t_rsp              w_res;
    logic              w_slot_free;
    logic              r_out_valid;
    t_rsp              r_out_rsp;

    fqcq_store u_store (
        .i_clk   (i_clk),
        .i_mem   (w_mem),
        .o_rdata (w_rdata)
    );

    fqcq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_in_valid),
        .i_req       (i_in_req),
        .o_idle      (w_idle),
        .o_mem       (w_mem),
        .i_rdata     (w_rdata),
        .o_res_valid (w_res_valid),
        .o_res       (w_res),
        .i_res_take  (w_slot_free)
    );

    // The output register can take a new beat when it is empty or its
    // current beat leaves at this edge.
    assign w_slot_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_slot_free) begin
            r_out_valid <= w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_slot_free && w_res_valid) begin
            r_out_rsp <= w_res;
        end
    end

    assign o_in_stall  = !w_idle;
    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out_rsp;

endmodule
